### hdl/usbcep_pkg.sv
// usbcep_pkg: shared types, codes and constants for the endpoint-zero handler
// no dependencies
`default_nettype none
package usbcep_pkg;

    localparam int NumEndpoints = 16;
    localparam int EpW = 4;
    localparam int QDepth = 2;

    typedef enum logic [1:0] {
        OP_BUS_RESET = 2'd0,
        OP_SETUP     = 2'd1,
        OP_IN_DONE   = 2'd2,
        OP_OUT_DONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ACT_NONE    = 4'd0,
        ACT_FIRST   = 4'd1,
        ACT_NEXT    = 4'd2,
        ACT_ZLP     = 4'd3,
        ACT_ARM_RX  = 4'd4,
        ACT_STALL   = 4'd5,
        ACT_FWD_IN  = 4'd6,
        ACT_FWD_OUT = 4'd7,
        ACT_IN_DONE = 4'd8
    } action_t;

    typedef enum logic [0:0] {
        REG_MAX_PACKET   = 1'd0,
        REG_SELF_POWERED = 1'd1
    } reg_idx_t;

    localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
    localparam logic [7:0] REQ_GET_INTERFACE  = 8'd10;
    localparam logic [7:0] REQ_SET_INTERFACE  = 8'd11;

    localparam logic [1:0] TYPE_STANDARD = 2'd0;
    localparam logic [1:0] TYPE_CLASS    = 2'd1;
    localparam logic [1:0] TYPE_VENDOR   = 2'd2;

    localparam logic [4:0] RCP_DEVICE    = 5'd0;
    localparam logic [4:0] RCP_INTERFACE = 5'd1;
    localparam logic [4:0] RCP_ENDPOINT  = 5'd2;

    localparam logic [15:0] FEAT_REMOTE_WAKEUP = 16'h0001;
    localparam logic [15:0] FEAT_TEST_MODE     = 16'h0002;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  ep_num;
        logic [7:0]  req_type;
        logic [7:0]  req_code;
        logic [15:0] req_value;
        logic [15:0] req_index;
        logic [15:0] req_length;
        logic [6:0]  rx_bytes;
        logic        ext_allow;
        logic [15:0] ext_length;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [6:0]  tx_len;
        logic        data_toggle;
        logic [15:0] reply_word;
        logic        reply_external;
        logic [6:0]  device_address;
        logic [3:0]  forward_ep;
    } out_word_t;

    // classified command handed from front to back
    typedef enum logic [3:0] {
        CMD_RESET, CMD_STALL, CMD_IN_REPLY, CMD_OUT_DATA,
        CMD_IN_DONE, CMD_OUT_DONE, CMD_FWD_IN, CMD_FWD_OUT
    } cmd_t;

    typedef enum logic [2:0] {
        SIDE_NONE, SIDE_CLR_WAKE, SIDE_SET_WAKE, SIDE_SET_TEST,
        SIDE_SET_HALT, SIDE_CLR_HALT, SIDE_SET_ADDR, SIDE_SET_CONFIG
    } side_t;

    typedef enum logic [1:0] {
        WORD_ZERO, WORD_DEVICE, WORD_EP_HALT, WORD_CONFIG
    } word_sel_t;

    typedef struct packed {
        cmd_t        cmd;
        side_t       side;
        word_sel_t   word_sel;
        logic        ext;
        logic [15:0] remain;
        logic [15:0] req_value;
        logic [7:0]  ep_addr;
        logic [15:0] last_req;
        logic [6:0]  rx_bytes;
        logic [3:0]  ep_num;
    } cmd_word_t;

    function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage
`default_nettype wire

### hdl/usbcep_front.sv
// usbcep_front: accepts events and classifies setup requests into commands
// depends on usbcep_pkg
`default_nettype none
module usbcep_front
    import usbcep_pkg::*;
(
    input  wire in_word_t  in_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    output cmd_word_t      cmd_data,
    output logic           cmd_valid,
    input  wire logic      cmd_full
);

    cmd_word_t c;
    logic [1:0] rtype;
    logic [4:0] rcp;
    logic       allow;

    assign in_stall  = cmd_full;
    assign cmd_valid = in_valid && !cmd_full;
    assign cmd_data  = c;

    always_comb
    begin
        rtype = in_data.req_type[6:5];
        rcp   = in_data.req_type[4:0];
        allow = 1'b0;
        c = '0;
        c.cmd       = CMD_RESET;
        c.side      = SIDE_NONE;
        c.word_sel  = WORD_ZERO;
        c.req_value = in_data.req_value;
        c.ep_addr   = in_data.req_index[7:0];
        c.last_req  = {in_data.req_type, in_data.req_code};
        c.rx_bytes  = in_data.rx_bytes;
        c.ep_num    = in_data.ep_num;
        case (op_t'(in_data.op))
            OP_BUS_RESET: c.cmd = CMD_RESET;
            OP_SETUP:
            begin
                if (rtype == TYPE_CLASS || rtype == TYPE_VENDOR)
                begin
                    allow = in_data.ext_allow;
                    c.remain = in_data.ext_length;
                    c.ext = 1'b1;
                end
                else if (rtype == TYPE_STANDARD)
                begin
                    case (in_data.req_code)
                        REQ_GET_STATUS:
                        begin
                            c.remain = 16'd2;
                            if (rcp == RCP_DEVICE)
                            begin
                                c.word_sel = WORD_DEVICE;
                                allow = 1'b1;
                            end
                            else if (rcp == RCP_INTERFACE)
                                allow = 1'b1;
                            else if (rcp == RCP_ENDPOINT)
                            begin
                                c.word_sel = WORD_EP_HALT;
                                allow = 1'b1;
                            end
                        end
                        REQ_CLEAR_FEATURE:
                        begin
                            if (rcp == RCP_DEVICE && in_data.req_value == FEAT_REMOTE_WAKEUP)
                            begin
                                c.side = SIDE_CLR_WAKE;
                                allow = 1'b1;
                            end
                            else if (rcp == RCP_ENDPOINT)
                            begin
                                c.side = SIDE_CLR_HALT;
                                allow = 1'b1;
                            end
                        end
                        REQ_SET_FEATURE:
                        begin
                            if (rcp == RCP_DEVICE && in_data.req_value == FEAT_REMOTE_WAKEUP)
                            begin
                                c.side = SIDE_SET_WAKE;
                                allow = 1'b1;
                            end
                            else if (rcp == RCP_DEVICE && in_data.req_value == FEAT_TEST_MODE)
                            begin
                                c.side = SIDE_SET_TEST;
                                allow = 1'b1;
                            end
                            else if (rcp == RCP_ENDPOINT)
                            begin
                                c.side = SIDE_SET_HALT;
                                allow = 1'b1;
                            end
                        end
                        REQ_SET_ADDRESS:
                            if (rcp == RCP_DEVICE)
                            begin
                                c.side = SIDE_SET_ADDR;
                                allow = 1'b1;
                            end
                        REQ_GET_DESCRIPTOR:
                            if (rcp == RCP_DEVICE || rcp == RCP_INTERFACE)
                            begin
                                allow = in_data.ext_allow;
                                c.remain = in_data.ext_length;
                                c.ext = 1'b1;
                            end
                        REQ_GET_CONFIG:
                            if (rcp == RCP_DEVICE)
                            begin
                                c.word_sel = WORD_CONFIG;
                                c.remain = 16'd1;
                                allow = 1'b1;
                            end
                        REQ_SET_CONFIG:
                            if (rcp == RCP_DEVICE)
                            begin
                                c.side = SIDE_SET_CONFIG;
                                allow = 1'b1;
                            end
                        REQ_GET_INTERFACE:
                            if (rcp == RCP_INTERFACE)
                            begin
                                allow = in_data.ext_allow;
                                c.remain = 16'd1;
                                c.ext = 1'b1;
                            end
                        REQ_SET_INTERFACE:
                            if (rcp == RCP_INTERFACE)
                                allow = in_data.ext_allow;
                        default: allow = 1'b0;
                    endcase
                end
                if (!allow)
                begin
                    c.cmd = CMD_STALL;
                    c.side = SIDE_NONE;
                end
                else if (in_data.req_type[7])
                begin
                    c.cmd = CMD_IN_REPLY;
                    c.remain = min16(c.remain, in_data.req_length);
                end
                else
                    c.cmd = CMD_OUT_DATA;
            end
            OP_IN_DONE:  c.cmd = (in_data.ep_num != '0) ? CMD_FWD_IN : CMD_IN_DONE;
            OP_OUT_DONE: c.cmd = (in_data.ep_num != '0) ? CMD_FWD_OUT : CMD_OUT_DONE;
            default: c.cmd = CMD_RESET;
        endcase
    end

endmodule
`default_nettype wire

### hdl/usbcep_queue.sv
// usbcep_queue: short command queue between front and back
// depends on usbcep_pkg
`default_nettype none
module usbcep_queue
    import usbcep_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_word_t wr_data,
    input  wire logic      wr_en,
    output logic           full,
    output cmd_word_t      rd_data,
    output logic           rd_valid,
    input  wire logic      rd_en
);

    localparam int PtrW = $clog2(QDepth);

    cmd_word_t         mem_reg [QDepth];
    logic [PtrW-1:0]   wp_reg, rp_reg;
    logic [PtrW:0]     cnt_reg;

    assign full     = (cnt_reg == (PtrW+1)'(QDepth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr_en)
        else $error("queue overrun");
    assert property (@(posedge clk) disable iff (!rst_n) !rd_valid |-> !rd_en)
        else $error("queue underrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PtrW+1)'(QDepth))
        else $error("queue count out of range");

endmodule
`default_nettype wire

### hdl/usbcep_back.sv
// usbcep_back: holds device state, executes commands, drives result register
// depends on usbcep_pkg
`default_nettype none
module usbcep_back
    import usbcep_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_word_t cmd_data,
    input  wire logic      cmd_valid,
    output logic           cmd_take,
    input  wire logic [6:0] ep0_pkt_size,
    input  wire logic      self_powered,
    output out_word_t      out_data,
    output logic           out_valid,
    input  wire logic      out_stall
);

    logic [6:0]  active_address_reg, active_address_next;
    logic [6:0]  pending_address_reg, pending_address_next;
    logic [7:0]  current_config_reg, current_config_next;
    logic        remote_wakeup_reg, remote_wakeup_next;
    logic        test_mode_reg, test_mode_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [6:0]  chunk_len_reg, chunk_len_next;
    logic [15:0] last_request_reg, last_request_next;
    logic        tx_toggle_reg, tx_toggle_next;
    logic [NumEndpoints-1:0] in_stall_bits_reg, in_stall_bits_next;
    logic [NumEndpoints-1:0] out_stall_bits_reg, out_stall_bits_next;
    out_word_t   out_reg, o;
    logic        out_valid_reg;

    logic [15:0] mps;
    logic [EpW-1:0] ep;
    logic        ep_ok, is_in_ep, halt_bit;
    logic [15:0] dec;
    logic [15:0] clip;

    assign cmd_take  = cmd_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        mps = (ep0_pkt_size < 7'd8) ? 16'd8 :
              (ep0_pkt_size > 7'd64) ? 16'd64 : {9'd0, ep0_pkt_size};
        ep       = cmd_data.ep_addr[EpW-1:0];
        ep_ok    = (32'(ep) < NumEndpoints);
        is_in_ep = cmd_data.ep_addr[7];
        halt_bit = ep_ok && (is_in_ep ? in_stall_bits_reg[ep] : out_stall_bits_reg[ep]);
        active_address_next  = active_address_reg;
        pending_address_next = pending_address_reg;
        current_config_next  = current_config_reg;
        remote_wakeup_next   = remote_wakeup_reg;
        test_mode_next       = test_mode_reg;
        bytes_left_next      = bytes_left_reg;
        chunk_len_next       = chunk_len_reg;
        last_request_next    = last_request_reg;
        tx_toggle_next       = tx_toggle_reg;
        in_stall_bits_next   = in_stall_bits_reg;
        out_stall_bits_next  = out_stall_bits_reg;
        dec = '0;
        clip = '0;
        o = '0;
        o.action = ACT_NONE;
        case (cmd_data.cmd)
            CMD_RESET:
            begin
                active_address_next  = '0;
                pending_address_next = '0;
                current_config_next  = '0;
                remote_wakeup_next   = 1'b0;
                test_mode_next       = 1'b0;
                bytes_left_next      = '0;
                chunk_len_next       = '0;
                last_request_next    = '0;
                tx_toggle_next       = 1'b0;
                in_stall_bits_next   = '0;
                out_stall_bits_next  = '0;
            end
            CMD_STALL, CMD_IN_REPLY, CMD_OUT_DATA:
            begin
                last_request_next = cmd_data.last_req;
                bytes_left_next   = '0;
                chunk_len_next    = '0;
                o.data_toggle     = 1'b1;
                case (cmd_data.side)
                    SIDE_CLR_WAKE:   remote_wakeup_next = 1'b0;
                    SIDE_SET_WAKE:   remote_wakeup_next = 1'b1;
                    SIDE_SET_TEST:   test_mode_next = 1'b1;
                    SIDE_SET_HALT:
                        if (ep_ok)
                        begin
                            if (is_in_ep)
                                in_stall_bits_next[ep] = 1'b1;
                            else
                                out_stall_bits_next[ep] = 1'b1;
                        end
                    SIDE_CLR_HALT:
                        if (ep_ok)
                        begin
                            if (is_in_ep)
                                in_stall_bits_next[ep] = 1'b0;
                            else
                                out_stall_bits_next[ep] = 1'b0;
                        end
                    SIDE_SET_ADDR:   pending_address_next = cmd_data.req_value[6:0];
                    SIDE_SET_CONFIG: current_config_next = cmd_data.req_value[7:0];
                    default: ;
                endcase
                if (cmd_data.cmd == CMD_STALL)
                    o.action = ACT_STALL;
                else if (cmd_data.cmd == CMD_IN_REPLY)
                begin
                    bytes_left_next = cmd_data.remain;
                    clip            = min16(cmd_data.remain, mps);
                    chunk_len_next  = clip[6:0];
                    tx_toggle_next  = 1'b1;
                    o.action = ACT_FIRST;
                    o.tx_len = chunk_len_next;
                    o.reply_external = cmd_data.ext;
                    case (cmd_data.word_sel)
                        WORD_DEVICE:  o.reply_word = {14'd0, remote_wakeup_reg, self_powered};
                        WORD_EP_HALT: o.reply_word = {15'd0, halt_bit};
                        WORD_CONFIG:  o.reply_word = {8'd0, current_config_reg};
                        default:      o.reply_word = '0;
                    endcase
                end
                else if (cmd_data.remain == '0)
                    o.action = ACT_ZLP;
                else
                begin
                    bytes_left_next = cmd_data.remain;
                    o.action = ACT_ARM_RX;
                end
            end
            CMD_IN_DONE:
            begin
                // standard device SetAddress, either direction
                if (last_request_reg[14:8] == 7'd0 && last_request_reg[7:0] == REQ_SET_ADDRESS)
                    active_address_next = pending_address_reg;
                dec = {9'd0, chunk_len_reg};
                bytes_left_next = (bytes_left_reg >= dec) ? bytes_left_reg - dec : '0;
                if (bytes_left_next != '0)
                begin
                    clip = min16(bytes_left_next, mps);
                    chunk_len_next = clip[6:0];
                    tx_toggle_next = !tx_toggle_reg;
                    o.action = ACT_NEXT;
                    o.tx_len = chunk_len_next;
                    o.data_toggle = tx_toggle_next;
                    o.reply_external = 1'b1;
                end
                else
                begin
                    o.action = ACT_IN_DONE;
                    o.data_toggle = 1'b1;
                end
            end
            CMD_OUT_DONE:
            begin
                dec = {9'd0, cmd_data.rx_bytes};
                bytes_left_next = (bytes_left_reg >= dec) ? bytes_left_reg - dec : '0;
                if (bytes_left_next == '0)
                begin
                    o.action = ACT_ZLP;
                    o.data_toggle = 1'b1;
                end
            end
            CMD_FWD_IN:
            begin
                o.action = ACT_FWD_IN;
                o.forward_ep = cmd_data.ep_num;
            end
            CMD_FWD_OUT:
            begin
                o.action = ACT_FWD_OUT;
                o.forward_ep = cmd_data.ep_num;
            end
            default: ;
        endcase
        o.device_address = active_address_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            out_reg <= o;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg       <= 1'b0;
            active_address_reg  <= '0;
            pending_address_reg <= '0;
            current_config_reg  <= '0;
            remote_wakeup_reg   <= 1'b0;
            test_mode_reg       <= 1'b0;
            bytes_left_reg      <= '0;
            chunk_len_reg       <= '0;
            last_request_reg    <= '0;
            tx_toggle_reg       <= 1'b0;
            in_stall_bits_reg   <= '0;
            out_stall_bits_reg  <= '0;
        end
        else
        begin
            if (cmd_take)
            begin
                out_valid_reg       <= 1'b1;
                active_address_reg  <= active_address_next;
                pending_address_reg <= pending_address_next;
                current_config_reg  <= current_config_next;
                remote_wakeup_reg   <= remote_wakeup_next;
                test_mode_reg       <= test_mode_next;
                bytes_left_reg      <= bytes_left_next;
                chunk_len_reg       <= chunk_len_next;
                last_request_reg    <= last_request_next;
                tx_toggle_reg       <= tx_toggle_next;
                in_stall_bits_reg   <= in_stall_bits_next;
                out_stall_bits_reg  <= out_stall_bits_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && cmd_data.cmd == CMD_RESET |=> active_address_reg == '0
        && in_stall_bits_reg == '0 && out_stall_bits_reg == '0)
        else $error("bus reset left state");
    assert property (@(posedge clk) disable iff (!rst_n)
        chunk_len_reg <= 7'd64)
        else $error("chunk longer than max packet");

endmodule
`default_nettype wire

### hdl/usb_control_endpoint_handler_top.sv
// usb_control_endpoint_handler_top: endpoint-zero control handler top level
// depends on usbcep_pkg, usbcep_front, usbcep_queue, usbcep_back
//
//   channel | direction | handshake        | word
//   in      | input     | in_valid/stall   | in_word_t
//   out     | output    | out_valid/stall  | out_word_t
//   cfg     | input     | cfg_we           | cfg_index, cfg_wdata
//
// one event per cycle sustained and one command executed per cycle by the back
// stage while out stall is low; a command is registered in the queue, then in the
// result register; rst_n clears all device state, mps resets to 64, self-powered
// to 0; out stall holds the result; the two-entry queue absorbs input until full
`default_nettype none
module usb_control_endpoint_handler_top
    import usbcep_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_word_t  in_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    output out_word_t      out_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire logic      cfg_we,
    input  wire logic      cfg_index,
    input  wire logic [6:0] cfg_wdata
);

    logic [6:0] ep0_pkt_size_reg;
    logic       self_powered_reg;
    cmd_word_t  f_cmd, q_cmd;
    logic       f_valid, q_full, q_valid, q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ep0_pkt_size_reg <= 7'd64;
            self_powered_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MAX_PACKET:   ep0_pkt_size_reg <= cfg_wdata;
                REG_SELF_POWERED: self_powered_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    usbcep_front u_front (
        .in_data(in_data), .in_valid(in_valid),
        .in_stall(in_stall), .cmd_data(f_cmd), .cmd_valid(f_valid), .cmd_full(q_full)
    );

    usbcep_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_data(f_cmd), .wr_en(f_valid), .full(q_full),
        .rd_data(q_cmd), .rd_valid(q_valid), .rd_en(q_take)
    );

    usbcep_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_data(q_cmd), .cmd_valid(q_valid),
        .cmd_take(q_take), .ep0_pkt_size(ep0_pkt_size_reg),
        .self_powered(self_powered_reg), .out_data(out_data),
        .out_valid(out_valid), .out_stall(out_stall)
    );

endmodule
`default_nettype wire

### tb/tb_ep0_checker.sv
// ep0 result checker: watches the in and out channels of the endpoint-zero handler,
// keeps its own copy of the device state and compares every result word
// depends on usbcep_pkg
`default_nettype none
module tb_ep0_checker
    import usbcep_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire in_word_t   in_data,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire out_word_t  out_data,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [6:0] cfg_wdata,
    output int              fail_count,
    output int              pending_count,
    output int              result_count
);

    logic [6:0]  mps_reg;
    logic        self_pwr;
    logic [6:0]  act_addr;
    logic [6:0]  pend_addr;
    logic [7:0]  cur_cfg;
    logic        wake_en;
    logic        test_en;
    logic [15:0] left_bytes;
    logic [6:0]  chunk;
    logic [15:0] last_req;
    logic        toggle;
    logic [15:0] in_halt;
    logic [15:0] out_halt;
    out_word_t   expected_words[$];

    function automatic logic [15:0] eff_size();
        if (mps_reg < 7'd8) return 16'd8;
        if (mps_reg > 7'd64) return 16'd64;
        return {9'd0, mps_reg};
    endfunction

    task automatic clear_device();
        act_addr = '0; pend_addr = '0; cur_cfg = '0; wake_en = 0; test_en = 0;
        left_bytes = '0; chunk = '0; last_req = '0; toggle = 0;
        in_halt = '0; out_halt = '0;
    endtask

    // mode 0 read, 1 set, 2 clear
    function automatic logic halt_access(input logic [7:0] addr, input int mode);
        logic [3:0] n;
        n = addr[3:0];
        if (addr[7])
        begin
            if (mode == 1) in_halt[n] = 1'b1;
            else if (mode == 2) in_halt[n] = 1'b0;
            return in_halt[n];
        end
        if (mode == 1) out_halt[n] = 1'b1;
        else if (mode == 2) out_halt[n] = 1'b0;
        return out_halt[n];
    endfunction

    task automatic predict_event(input in_word_t w);
        out_word_t   r;
        logic [1:0]  rtype;
        logic [4:0]  rcp;
        logic [15:0] remain;
        logic        allow;
        logic        dummy;
        logic [15:0] lim;
        logic [15:0] used;
        r = '0;
        remain = '0;
        allow = 0;
        lim = eff_size();
        case (op_t'(w.op))
            OP_BUS_RESET: clear_device();
            OP_SETUP:
            begin
                rtype = w.req_type[6:5];
                rcp = w.req_type[4:0];
                last_req = {w.req_type, w.req_code};
                left_bytes = '0;
                chunk = '0;
                if (rtype == TYPE_CLASS || rtype == TYPE_VENDOR)
                begin
                    allow = w.ext_allow; remain = w.ext_length; r.reply_external = 1;
                end
                else if (rtype == TYPE_STANDARD)
                begin
                    case (w.req_code)
                        REQ_GET_STATUS:
                        begin
                            if (rcp == RCP_DEVICE)
                            begin
                                r.reply_word = {14'd0, wake_en, self_pwr}; allow = 1;
                            end
                            else if (rcp == RCP_INTERFACE) allow = 1;
                            else if (rcp == RCP_ENDPOINT)
                            begin
                                r.reply_word = {15'd0, halt_access(w.req_index[7:0], 0)};
                                allow = 1;
                            end
                            remain = 16'd2;
                        end
                        REQ_CLEAR_FEATURE:
                            if (rcp == RCP_DEVICE && w.req_value == FEAT_REMOTE_WAKEUP)
                            begin
                                wake_en = 0; allow = 1;
                            end
                            else if (rcp == RCP_ENDPOINT)
                            begin
                                dummy = halt_access(w.req_index[7:0], 2); allow = 1;
                            end
                        REQ_SET_FEATURE:
                            if (rcp == RCP_DEVICE && w.req_value == FEAT_REMOTE_WAKEUP)
                            begin
                                wake_en = 1; allow = 1;
                            end
                            else if (rcp == RCP_DEVICE && w.req_value == FEAT_TEST_MODE)
                            begin
                                test_en = 1; allow = 1;
                            end
                            else if (rcp == RCP_ENDPOINT)
                            begin
                                dummy = halt_access(w.req_index[7:0], 1); allow = 1;
                            end
                        REQ_SET_ADDRESS:
                            if (rcp == RCP_DEVICE)
                            begin
                                pend_addr = w.req_value[6:0]; allow = 1;
                            end
                        REQ_GET_DESCRIPTOR:
                            if (rcp <= RCP_INTERFACE)
                            begin
                                allow = w.ext_allow; remain = w.ext_length;
                                r.reply_external = 1;
                            end
                        REQ_GET_CONFIG:
                            if (rcp == RCP_DEVICE)
                            begin
                                r.reply_word = {8'd0, cur_cfg}; remain = 16'd1; allow = 1;
                            end
                        REQ_SET_CONFIG:
                            if (rcp == RCP_DEVICE)
                            begin
                                cur_cfg = w.req_value[7:0]; allow = 1;
                            end
                        REQ_GET_INTERFACE:
                            if (rcp == RCP_INTERFACE)
                            begin
                                allow = w.ext_allow; remain = 16'd1; r.reply_external = 1;
                            end
                        REQ_SET_INTERFACE:
                            if (rcp == RCP_INTERFACE) allow = w.ext_allow;
                        default: ;
                    endcase
                end
                r.data_toggle = 1;
                if (!allow)
                begin
                    r.action = ACT_STALL; r.reply_word = '0; r.reply_external = 0;
                end
                else if (w.req_type[7])
                begin
                    if (w.req_length < remain) remain = w.req_length;
                    left_bytes = remain;
                    chunk = (remain < lim) ? remain[6:0] : lim[6:0];
                    toggle = 1;
                    r.action = ACT_FIRST; r.tx_len = chunk;
                end
                else
                begin
                    r.reply_word = '0; r.reply_external = 0;
                    if (remain == 0) r.action = ACT_ZLP;
                    else
                    begin
                        left_bytes = remain; r.action = ACT_ARM_RX;
                    end
                end
            end
            OP_IN_DONE:
                if (w.ep_num != 0)
                begin
                    r.action = ACT_FWD_IN; r.forward_ep = w.ep_num;
                end
                else
                begin
                    // standard device SetAddress, either direction
                    if (last_req[14:13] == 2'd0 && last_req[12:8] == RCP_DEVICE
                        && last_req[7:0] == REQ_SET_ADDRESS)
                        act_addr = pend_addr;
                    used = {9'd0, chunk};
                    left_bytes = (left_bytes >= used) ? left_bytes - used : '0;
                    if (left_bytes != 0)
                    begin
                        chunk = (left_bytes < lim) ? left_bytes[6:0] : lim[6:0];
                        toggle = ~toggle;
                        r.action = ACT_NEXT; r.tx_len = chunk; r.data_toggle = toggle;
                        r.reply_external = 1;
                    end
                    else
                    begin
                        r.action = ACT_IN_DONE; r.data_toggle = 1;
                    end
                end
            default:
                if (w.ep_num != 0)
                begin
                    r.action = ACT_FWD_OUT; r.forward_ep = w.ep_num;
                end
                else
                begin
                    used = {9'd0, w.rx_bytes};
                    left_bytes = (left_bytes >= used) ? left_bytes - used : '0;
                    if (left_bytes == 0)
                    begin
                        r.action = ACT_ZLP; r.data_toggle = 1;
                    end
                end
        endcase
        r.device_address = act_addr;
        expected_words.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t e;
        if (!rst_n)
        begin
            mps_reg = 7'd64;
            self_pwr = 0;
            clear_device();
            expected_words.delete();
            fail_count = 0;
            result_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (e.action != out_data.action
                        || e.tx_len != out_data.tx_len
                        || e.data_toggle != out_data.data_toggle
                        || e.reply_word != out_data.reply_word
                        || e.reply_external != out_data.reply_external
                        || e.device_address != out_data.device_address
                        || e.forward_ep != out_data.forward_ep)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall) predict_event(in_data);
            if (cfg_we)
            begin
                if (reg_idx_t'(cfg_index) == REG_MAX_PACKET) mps_reg = cfg_wdata;
                else self_pwr = cfg_wdata[0];
            end
        end
        pending_count = expected_words.size();
    end

endmodule
`default_nettype wire

### tb/tb_top.sv
// tb_top: stimulus, clock, reset and verdict for the endpoint-zero handler
// depends on usbcep_pkg, usb_control_endpoint_handler_top, tb_ep0_checker
`default_nettype none
module tb_top;
    import usbcep_pkg::*;

    logic       clk = 0;
    logic       rst_n = 0;
    in_word_t   in_data = '0;
    logic       in_valid = 0;
    logic       in_stall;
    out_word_t  out_data;
    logic       out_valid;
    logic       out_stall = 0;
    logic       cfg_we = 0;
    logic       cfg_index = 0;
    logic [6:0] cfg_wdata = '0;
    int         fail_count;
    int         pending_count;
    int         result_count;
    int         cycles = 0;
    int         stall_mode = 0;
    int         sent = 0;

    usb_control_endpoint_handler_top DUT (.*);
    tb_ep0_checker u_checker (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern: phases of none, light, heavy
    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    task automatic send_word(input in_word_t w);
        in_data <= w;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        if (n > 0)
        begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [6:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    function automatic in_word_t make_setup(input logic [7:0] rt, input logic [7:0] code,
                                            input logic [15:0] val, input logic [15:0] idx,
                                            input logic [15:0] len);
        in_word_t w;
        w = '0;
        w.op = OP_SETUP;
        w.req_type = rt;
        w.req_code = code;
        w.req_value = val;
        w.req_index = idx;
        w.req_length = len;
        w.ext_allow = $urandom_range(0, 3) != 0;
        w.ext_length = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
        return w;
    endfunction

    function automatic in_word_t make_done(input op_t op, input logic [3:0] ep);
        in_word_t w;
        w = in_word_t'(($bits(in_word_t))'({$urandom, $urandom, $urandom, $urandom}));
        w.op = op;
        w.ep_num = ep;
        w.rx_bytes = 7'($urandom_range(0, 64));
        return w;
    endfunction

    function automatic in_word_t random_setup();
        logic [7:0]  rt;
        logic [7:0]  codes[9];
        logic [15:0] len;
        codes = '{REQ_GET_STATUS, REQ_CLEAR_FEATURE, REQ_SET_FEATURE, REQ_SET_ADDRESS,
                  REQ_GET_DESCRIPTOR, REQ_GET_CONFIG, REQ_SET_CONFIG, REQ_GET_INTERFACE,
                  REQ_SET_INTERFACE};
        rt = {1'($urandom), 2'($urandom_range(0, 5) == 0 ? $urandom : 0),
              5'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 2))};
        len = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 150));
        return make_setup(rt, ($urandom_range(0, 9) == 0) ? 8'($urandom)
                              : codes[$urandom_range(0, 8)],
                          ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom),
                          16'($urandom), len);
    endfunction

    task automatic random_phase(input int count);
        int k;
        int n;
        in_word_t w;
        k = 0;
        while (k < count)
        begin
            w = random_setup();
            send_word(w);
            k++;
            n = $urandom_range(0, 5);
            repeat (n)
            begin
                idle_gap();
                case ($urandom_range(0, 19))
                    0: w = make_done(OP_BUS_RESET, 4'($urandom));
                    1, 2: w = make_done(OP_IN_DONE, 4'($urandom));
                    3: w = make_done(OP_OUT_DONE, 4'($urandom));
                    4, 5, 6, 7, 8, 9, 10, 11: w = make_done(OP_IN_DONE, 4'd0);
                    default: w = make_done(OP_OUT_DONE, 4'd0);
                endcase
                send_word(w);
                k++;
            end
            idle_gap();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed part
        send_word(make_setup(8'h80, REQ_GET_STATUS, 0, 0, 16'hffff));
        send_word(make_setup(8'h00, REQ_SET_FEATURE, FEAT_REMOTE_WAKEUP, 0, 0));
        send_word(make_setup(8'h00, REQ_SET_FEATURE, FEAT_TEST_MODE, 0, 0));
        send_word(make_setup(8'h02, REQ_SET_FEATURE, 0, 16'h0081, 0));
        send_word(make_setup(8'h02, REQ_SET_FEATURE, 16'hffff, 16'hff0f, 0));
        send_word(make_setup(8'h82, REQ_GET_STATUS, 0, 16'h0081, 2));
        send_word(make_setup(8'h02, REQ_CLEAR_FEATURE, 0, 16'h0081, 0));
        send_word(make_setup(8'h00, REQ_SET_ADDRESS, 16'hffff, 0, 0));
        send_word(make_done(OP_IN_DONE, 0));
        send_word(make_setup(8'h80, REQ_SET_ADDRESS, 16'h0023, 0, 0));
        send_word(make_done(OP_IN_DONE, 0));
        send_word(make_setup(8'h00, REQ_SET_CONFIG, 16'h00ff, 0, 0));
        send_word(make_setup(8'h80, REQ_GET_CONFIG, 0, 0, 1));
        send_word(make_setup(8'h81, REQ_GET_INTERFACE, 0, 0, 1));
        send_word(make_setup(8'h01, REQ_SET_INTERFACE, 0, 0, 0));
        send_word(make_setup(8'h80, REQ_GET_DESCRIPTOR, 16'h0100, 0, 16'hffff));
        send_word(make_done(OP_IN_DONE, 0));
        send_word(make_done(OP_IN_DONE, 0));
        send_word(make_setup(8'h21, 8'hff, 0, 0, 16'h0100));
        send_word(make_done(OP_OUT_DONE, 0));
        send_word(make_done(OP_OUT_DONE, 4'hf));
        send_word(make_done(OP_IN_DONE, 4'hf));
        send_word(make_setup(8'h60, 8'h00, 0, 0, 0));
        send_word(make_setup(8'h03, 8'h77, 0, 0, 0));
        send_word(make_done(OP_BUS_RESET, 0));
        drain();
        // random phases across register settings, extremes included
        write_reg(REG_MAX_PACKET, 7'd0);
        write_reg(REG_SELF_POWERED, 7'd1);
        random_phase(250);
        drain();
        write_reg(REG_MAX_PACKET, 7'd127);
        random_phase(250);
        drain();
        write_reg(REG_MAX_PACKET, 7'd8);
        write_reg(REG_SELF_POWERED, 7'd0);
        random_phase(250);
        drain();
        write_reg(REG_MAX_PACKET, 7'($urandom_range(9, 63)));
        write_reg(REG_SELF_POWERED, {6'd0, 1'($urandom)});
        random_phase(300);
        drain();
        $display("sent %0d events, checked %0d results over four packet-size settings",
                 sent, result_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
